// ===== rtl/psf_pkg.sv =====
// psf_pkg: shared types and constants for the pulse segment finder.
// Holds widths, the sample index limit and the result item struct.
// No dependencies.
package psf_pkg;

    // Waveform length and sample width
    localparam int WAVE_LEN    = 65536;
    localparam int SAMPLE_BITS = 16;

    localparam int CNT_W   = 16;
    localparam int TRIG_W  = 15;
    // Wide enough to compare a signed sample against threshold plus tail
    localparam int CMP_W   = SAMPLE_BITS + 2;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam int IDX_LIM_INT = (WAVE_LEN - 1 > 65535) ? 65535 : (WAVE_LEN - 1);
    localparam logic [CNT_W-1:0] INDEX_LIMIT = CNT_W'(IDX_LIM_INT);

    // Result queue depth
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [CNT_W-1:0] end_index;
        logic [CNT_W-1:0] segment_length;
        logic [CNT_W-1:0] rise_position;
    } result_t;

endpackage

// ===== rtl/pulse_segment_finder.sv =====
// pulse_segment_finder: top level; tracker front, result queue, output back.
// Depends on psf_pkg, psf_tracker, psf_queue, psf_out.
// Throughput: one sample per cycle; a sample is taken while the result queue
// (4 entries) has room; the output side affects this only through the queue fill.
// A result is queued as its sample is accepted, then shown on m_ from the output register once it is free.
// Reset: synchronous active-low aresetn clears run state, trigger_level and
// the queue; no clearing pass.
module pulse_segment_finder (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_wr_en,
    input  logic [psf_pkg::TRIG_W-1:0]              cfg_wr_data,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [psf_pkg::SAMPLE_BITS-1:0]  s_sample_value,
    input  logic                                    s_last_sample,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [psf_pkg::CNT_W-1:0]               m_end_index,
    output logic [psf_pkg::CNT_W-1:0]               m_segment_length,
    output logic [psf_pkg::CNT_W-1:0]               m_rise_position
);
    import psf_pkg::*;

    logic [TRIG_W-1:0] trigger_level_reg;
    logic              accept, emit, q_not_empty, q_not_full, q_pop;
    result_t           trk_result, q_head, out_data;

    // Threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trigger_level_reg <= '0;
        end else if (cfg_wr_en) begin
            trigger_level_reg <= cfg_wr_data;
        end
    end

    assign s_ready = q_not_full;
    assign accept  = s_valid && s_ready;

    psf_tracker u_tracker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .trigger_level (trigger_level_reg),
        .accept        (accept),
        .sample_value  (s_sample_value),
        .last_sample   (s_last_sample),
        .emit          (emit),
        .result        (trk_result)
    );

    psf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (emit),
        .push_data (trk_result),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .not_full  (q_not_full),
        .head_data (q_head)
    );

    psf_out u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_data    (out_data)
    );

    assign m_end_index      = out_data.end_index;
    assign m_segment_length = out_data.segment_length;
    assign m_rise_position  = out_data.rise_position;

endmodule

// ===== rtl/psf_tracker.sv =====
// psf_tracker: front part; accepts samples, tracks the run state and
// classifies each item into extend, close or tail update. Uses psf_pkg.
module psf_tracker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [psf_pkg::TRIG_W-1:0]          trigger_level,
    input  logic                                accept,
    input  logic signed [psf_pkg::SAMPLE_BITS-1:0] sample_value,
    input  logic                                last_sample,
    output logic                                emit,
    output psf_pkg::result_t                    result
);
    import psf_pkg::*;

    logic [CNT_W-1:0]        sample_index_reg, sample_index_next;
    logic [CNT_W-1:0]        run_length_reg, run_length_next;
    logic [SAMPLE_BITS-1:0]  run_max_reg, run_max_next;
    logic [CNT_W-1:0]        max_position_reg, max_position_next;
    logic [SAMPLE_BITS-1:0]  tail_level_reg, tail_level_next;

    logic signed [CMP_W-1:0] s_ext, th_ext, tail_ext, max_ext;
    logic                    above_tail, above_th, new_max, dropped;
    logic [CNT_W-1:0]        len_inc;

    // Operands widened so every compare is exact
    always_comb begin
        s_ext    = CMP_W'(sample_value);
        th_ext   = CMP_W'(trigger_level);
        tail_ext = CMP_W'(tail_level_reg);
        max_ext  = CMP_W'(run_max_reg);
    end

    // Classification of the current item
    assign above_tail = s_ext > (th_ext + tail_ext);
    assign above_th   = s_ext > th_ext;
    assign new_max    = max_ext < s_ext;
    assign dropped    = s_ext <= (max_ext - th_ext);
    assign len_inc    = (run_length_reg != CNT_MAX) ? run_length_reg + 1'b1 : run_length_reg;

    assign emit = accept && above_tail && !new_max && dropped;
    assign result.end_index      = sample_index_reg;
    assign result.segment_length = len_inc;
    assign result.rise_position  = max_position_reg;

    // Next-state logic
    always_comb begin
        sample_index_next = sample_index_reg;
        run_length_next   = run_length_reg;
        run_max_next      = run_max_reg;
        max_position_next = max_position_reg;
        tail_level_next   = tail_level_reg;
        if (accept) begin
            if (above_tail) begin
                run_length_next = len_inc;
                if (new_max) begin
                    run_max_next      = sample_value;
                    max_position_next = len_inc;
                end else if (dropped) begin
                    run_length_next   = '0;
                    run_max_next      = '0;
                    max_position_next = '0;
                    tail_level_next   = sample_value;
                end
            end else if (above_th) begin
                if (s_ext < tail_ext) begin
                    tail_level_next = sample_value;
                end
            end else begin
                tail_level_next = '0;
            end
            if (sample_index_reg < INDEX_LIMIT) begin
                sample_index_next = sample_index_reg + 1'b1;
            end
            if (last_sample) begin
                sample_index_next = '0;
                run_length_next   = '0;
                run_max_next      = '0;
                max_position_next = '0;
                tail_level_next   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_index_reg <= '0;
            run_length_reg   <= '0;
            run_max_reg      <= '0;
            max_position_reg <= '0;
            tail_level_reg   <= '0;
        end else begin
            sample_index_reg <= sample_index_next;
            run_length_reg   <= run_length_next;
            run_max_reg      <= run_max_next;
            max_position_reg <= max_position_next;
            tail_level_reg   <= tail_level_next;
        end
    end

    // A closing item always follows a recorded maximum
    a_rise_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (result.rise_position != '0))
        else $error("segment closed without a recorded maximum");

    // Maximum and tail hold non-negative sample values only
    a_max_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        !run_max_reg[SAMPLE_BITS-1] && !tail_level_reg[SAMPLE_BITS-1])
        else $error("run maximum or tail went negative");

    // Last item clears the whole run state
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && last_sample) |=> (sample_index_reg == '0 && run_length_reg == '0
                                     && max_position_reg == '0))
        else $error("state not cleared after last item");

endmodule

// ===== rtl/psf_queue.sv =====
// psf_queue: short result queue between the tracker and the output stage.
// Register based, one push and one pop per cycle. Uses psf_pkg.
module psf_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  psf_pkg::result_t push_data,
    input  logic             pop,
    output logic             not_empty,
    output logic             not_full,
    output psf_pkg::result_t head_data
);
    import psf_pkg::*;

    result_t              entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;

    assign not_empty = count_reg != '0;
    assign not_full  = count_reg != Q_CNT_W'(Q_DEPTH);
    assign head_data = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (not_full || pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count out of range");

endmodule

// ===== rtl/psf_out.sv =====
// psf_out: back part; moves results from the queue into the output
// register and holds them until taken. Uses psf_pkg.
module psf_out (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_not_empty,
    input  psf_pkg::result_t q_head,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output psf_pkg::result_t out_data
);
    import psf_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    // Load whenever the output register is free or being emptied
    assign q_pop      = q_not_empty && (!valid_reg || out_ready);
    assign valid_next = q_pop || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            data_reg <= q_head;
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !out_ready) |=> (valid_reg && $stable(data_reg)))
        else $error("stalled output item changed");

    a_no_pop_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !out_ready) |-> !q_pop)
        else $error("pop while output stalled");

    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> valid_reg)
        else $error("popped item not shown");

endmodule

// ===== tb/tb_pulse_segment_finder.sv =====
// tb_pulse_segment_finder: self-checking testbench for the pulse segment finder. Drives
// samples through a scripted and a random waveform phase and checks each result item
// against a cycle-free predictor or typed script row. Needs psf_pkg, pulse_segment_finder.
module tb_pulse_segment_finder;
    import psf_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SCRIPT_LEN   = 19;

    typedef enum bit {STEP_CFG, STEP_SAMPLE} step_kind_t;

    // One scripted step; e_* only used when typed is set
    typedef struct {
        step_kind_t kind;
        int         value;
        bit         last;
        bit         typed;
        bit         hit;
        int         e_idx;
        int         e_len;
        int         e_rise;
    } script_row_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [TRIG_W-1:0]             cfg_wr_data = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic signed [SAMPLE_BITS-1:0] s_sample_value = '0;
    logic                          s_last_sample = 1'b0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [CNT_W-1:0]              m_end_index;
    logic [CNT_W-1:0]              m_segment_length;
    logic [CNT_W-1:0]              m_rise_position;

    // Predictor state
    logic [TRIG_W-1:0] trig_q = '0;
    logic [CNT_W-1:0]  idx_q = '0;
    logic [CNT_W-1:0]  len_q = '0;
    logic [CNT_W-1:0]  pos_q = '0;
    int                max_q = 0;
    int                tail_q = 0;

    result_t     pending_segments [$];
    int          error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    // Directed script: reset threshold, both threshold extremes, tail handling
    script_row_t sample_script [SCRIPT_LEN] = '{
        '{STEP_SAMPLE,      0, 1'b0, 1'b1, 1'b0, 0, 0, 0},
        '{STEP_SAMPLE,    100, 1'b0, 1'b0, 1'b0, 0, 0, 0},
        '{STEP_SAMPLE,    100, 1'b0, 1'b1, 1'b1, 2, 2, 1},
        '{STEP_SAMPLE, -32768, 1'b0, 1'b0, 1'b0, 0, 0, 0},
        '{STEP_SAMPLE,  32767, 1'b1, 1'b0, 1'b0, 0, 0, 0},
        '{STEP_CFG,     32767, 1'b0, 1'b0, 1'b0, 0, 0, 0},
        '{STEP_SAMPLE,  32767, 1'b0, 1'b1, 1'b0, 0, 0, 0},
        '{STEP_SAMPLE,     -1, 1'b1, 1'b1, 1'b0, 0, 0, 0},
        '{STEP_CFG,      1000, 1'b0, 1'b0, 1'b0, 0, 0, 0},
        '{STEP_SAMPLE,    500, 1'b0, 1'b0, 1'b0, 0, 0, 0},
        '{STEP_SAMPLE,   1500, 1'b0, 1'b0, 1'b0, 0, 0, 0},
        '{STEP_SAMPLE,   3000, 1'b0, 1'b0, 1'b0, 0, 0, 0},
        '{STEP_SAMPLE,   2500, 1'b0, 1'b0, 1'b0, 0, 0, 0},
        '{STEP_SAMPLE,   1900, 1'b0, 1'b0, 1'b0, 0, 0, 0},
        '{STEP_SAMPLE,   1500, 1'b0, 1'b0, 1'b0, 0, 0, 0},
        '{STEP_SAMPLE,   2000, 1'b0, 1'b0, 1'b0, 0, 0, 0},
        '{STEP_SAMPLE,   2600, 1'b0, 1'b0, 1'b0, 0, 0, 0},
        '{STEP_SAMPLE,   1000, 1'b0, 1'b0, 1'b0, 0, 0, 0},
        '{STEP_SAMPLE,   1001, 1'b1, 1'b0, 1'b0, 0, 0, 0}
    };

    pulse_segment_finder DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample_value   (s_sample_value),
        .s_last_sample    (s_last_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_end_index      (m_end_index),
        .m_segment_length (m_segment_length),
        .m_rise_position  (m_rise_position)
    );

    always #5 aclk = ~aclk;

    // Advance the segment tracker by one sample; returns 1 when a segment closes
    function automatic bit predict_segment_close(input logic signed [SAMPLE_BITS-1:0] smp,
                                                 input bit last_mark, output result_t res);
        int s;
        int th;
        bit hit;
        s   = int'(smp);
        th  = int'(trig_q);
        hit = 1'b0;
        res = '0;
        if (s > th + tail_q) begin
            if (len_q != CNT_MAX)
                len_q++;
            if (max_q < s) begin
                max_q = s;
                pos_q = len_q;
            end else if (s <= max_q - th) begin
                res    = '{idx_q, len_q, pos_q};
                hit    = 1'b1;
                len_q  = '0;
                max_q  = 0;
                pos_q  = '0;
                tail_q = s;
            end
        end else if (s > th) begin
            // between threshold and threshold plus tail: tail can only drop
            if (s < tail_q)
                tail_q = s;
        end else begin
            tail_q = 0;
        end
        if (idx_q < INDEX_LIMIT)
            idx_q++;
        if (last_mark) begin
            idx_q  = '0;
            len_q  = '0;
            max_q  = 0;
            pos_q  = '0;
            tail_q = 0;
        end
        return hit;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(input int v);
        int c;
        c = (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
        return 16'(c);
    endfunction

    task automatic report_failure(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // Offer one sample, wait for acceptance, then record what it should produce
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp, input bit last_mark,
                               input bit typed = 1'b0, input bit typed_hit = 1'b0,
                               input result_t typed_res = '0);
        result_t res;
        bit      hit;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_sample_value <= smp;
        s_last_sample  <= last_mark;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        hit = predict_segment_close(smp, last_mark, res);
        if (typed) begin
            hit = typed_hit;
            res = typed_res;
        end
        if (hit)
            pending_segments = {pending_segments, res};
    endtask

    // Threshold write: only once the block has drained
    task automatic write_trigger(input int level);
        s_valid <= 1'b0;
        while (pending_segments.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= 15'(level);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        trig_q = 15'(level);
    endtask

    // Mostly well-formed pulses (baseline, rise, optional flat top, decay), some raw noise
    task automatic run_random_waves(input int item_goal);
        int sent;
        int tr;
        int peak;
        int rise_n;
        int fall_n;
        int jit;
        int lvl;
        sent = 0;
        tr   = int'(trig_q);
        while (sent < item_goal) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 8)) begin
                    send_sample(16'($urandom), $urandom_range(0, 29) == 0);
                    sent++;
                end
            end else begin
                repeat ($urandom_range(0, 4)) begin
                    send_sample(clamp_sample(int'($urandom_range(0, 2 * tr)) - tr), 1'b0);
                    sent++;
                end
                peak   = (tr >= 32767) ? 32767 : tr + int'($urandom_range(1, 32767 - tr));
                rise_n = $urandom_range(1, 5);
                fall_n = $urandom_range(1, 6);
                jit    = peak / 32 + 1;
                for (int k = 1; k <= rise_n; k++) begin
                    lvl = tr + (peak - tr) * k / rise_n + int'($urandom_range(0, 2 * jit)) - jit;
                    send_sample(clamp_sample(lvl), $urandom_range(0, 59) == 0);
                    sent++;
                end
                if ($urandom_range(0, 2) == 0) begin
                    send_sample(clamp_sample(peak), 1'b0);
                    sent++;
                end
                for (int k = 1; k <= fall_n; k++) begin
                    lvl = peak - peak * k / fall_n + int'($urandom_range(0, 2 * jit)) - jit;
                    send_sample(clamp_sample(lvl), (k == fall_n) && ($urandom_range(0, 11) == 0));
                    sent++;
                end
            end
        end
    endtask

    // Result side: check accepted items, stall at random
    always @(posedge aclk) begin : result_check
        result_t exp_seg;
        if (aresetn && m_valid && m_ready) begin
            if (pending_segments.size() == 0) begin
                report_failure($sformatf("unexpected result end_index=%0d length=%0d rise=%0d",
                                         m_end_index, m_segment_length, m_rise_position));
            end else begin
                exp_seg = pending_segments.pop_front();
                if (m_end_index !== exp_seg.end_index)
                    report_failure($sformatf("end_index expected %0d got %0d",
                                             exp_seg.end_index, m_end_index));
                if (m_segment_length !== exp_seg.segment_length)
                    report_failure($sformatf("segment_length expected %0d got %0d",
                                             exp_seg.segment_length, m_segment_length));
                if (m_rise_position !== exp_seg.rise_position)
                    report_failure($sformatf("rise_position expected %0d got %0d",
                                             exp_seg.rise_position, m_rise_position));
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        script_row_t row;
        result_t     typed_res;
        int          level;
        int          drain_cycles;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed script
        foreach (sample_script[i]) begin
            row = sample_script[i];
            if (row.kind == STEP_CFG) begin
                write_trigger(row.value);
            end else begin
                typed_res = '{16'(row.e_idx), 16'(row.e_len), 16'(row.e_rise)};
                send_sample(16'(row.value), row.last, row.typed, row.hit, typed_res);
            end
        end

        // Random waveforms: free flow, sender gaps, receiver stalls, both
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            repeat (2) begin
                case ($urandom_range(0, 5))
                    0: level = 0;
                    1: level = $urandom_range(1, 16);
                    5: level = $urandom_range(20000, 32767);
                    default: level = $urandom_range(100, 4000);
                endcase
                write_trigger(level);
                run_random_waves(140);
            end
        end

        // Drain and finish
        s_valid <= 1'b0;
        drain_cycles = 0;
        while (pending_segments.size() != 0 && drain_cycles < 5000) begin
            @(posedge aclk);
            drain_cycles++;
        end
        repeat (8) @(posedge aclk);
        if (pending_segments.size() != 0)
            report_failure($sformatf("%0d expected results never arrived",
                                     pending_segments.size()));
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
